/* rtl/core/atm_pkg.sv */
// ============================================================================
// atm_pkg
// Shared types, codes and helpers for the alarm table time match block.
// ============================================================================
`default_nettype none

package atm_pkg;

  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned MASK_W        = 5;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_ONCE     = 2'd0,
    MODE_PERIODIC = 2'd1,
    MODE_DAILY    = 2'd2,
    MODE_WEEKLY   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // One alarm slot as held in the table memory.
  typedef struct packed {
    mode_e      mode;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [7:0] period;
  } slot_entry_t;

  // Finished result handed from the sequencer to the output stage.
  typedef struct packed {
    logic              vld;
    logic [MASK_W-1:0] fired_mask;
  } result_t;

  // (hour + period) mod 24. Split off the low three bits, then take the
  // upper part mod 3 through a reciprocal multiply (x * 171 >> 9 is exact
  // for x up to 35, and the sum never exceeds 286).
  function automatic logic [4:0] hour_advance(input logic [4:0] h, input logic [7:0] p);
    logic [8:0]  sum;
    logic [5:0]  upper;
    logic [13:0] prod;
    logic [4:0]  quot;
    logic [5:0]  rem;
    sum   = {4'b0000, h} + {1'b0, p};
    upper = sum[8:3];
    prod  = {8'd0, upper} * 14'd171;
    quot  = prod[13:9];
    rem   = upper - 6'({1'b0, quot} * 6'd3);
    return {rem[1:0], sum[2:0]};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/atm_if.sv */
// ============================================================================
// atm_if
// Handshake channels for alarm commands and fired-mask results.
// ============================================================================
`default_nettype none

interface atm_req_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [2:0] slot;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
  logic [1:0] mode;
  logic [7:0] period;

  modport source (output valid, command, slot, hour, minute, second, mode, period,
                  input ready);
  modport sink   (input valid, command, slot, hour, minute, second, mode, period,
                  output ready);
endinterface

interface atm_rsp_if;
  logic       valid;
  logic       ready;
  logic [4:0] fired_mask;

  modport source (output valid, fired_mask, input ready);
  modport sink   (input valid, fired_mask, output ready);
endinterface

`default_nettype wire

/* rtl/core/atm_ram.sv */
// ============================================================================
// atm_ram
// Generic single-write, single-read memory with registered read data.
// ============================================================================
`default_nettype none

module atm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/atm_ctrl.sv */
// ============================================================================
// atm_ctrl
// Command sequencer: writes slots, scans the table on a tick, updates hits.
// ============================================================================
`default_nettype none

module atm_ctrl #(
  parameter int unsigned NUM_SLOTS = 5
) (
  input  wire logic         clk,
  input  wire logic         rst,
  atm_req_if.sink           req,
  output atm_pkg::result_t  res,
  input  wire logic         res_ready
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  atm_pkg::state_e      state, state_next;
  logic [IDX_W-1:0]     idx;
  logic [NUM_SLOTS-1:0] en;
  logic [atm_pkg::MASK_W-1:0] mask;
  logic [4:0]           t_hour;
  logic [5:0]           t_minute;
  logic [5:0]           t_second;

  logic                 accept;
  logic                 is_set;
  logic                 slot_ok;
  logic [7:0]           slot_ext;
  logic [IDX_W-1:0]     slot_addr;
  logic                 last;
  logic                 hit;
  logic [atm_pkg::MASK_W-1:0] hit_bits;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  atm_pkg::slot_entry_t ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  atm_pkg::slot_entry_t ram_rdata;

  atm_ram #(
    .WIDTH ($bits(atm_pkg::slot_entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    req.ready = (state == atm_pkg::ST_IDLE);
    accept    = req.valid && req.ready;
    is_set    = (atm_pkg::cmd_e'(req.command) == atm_pkg::CMD_SET);
    slot_ext  = {5'd0, req.slot};
    slot_ok   = (slot_ext < 8'(NUM_SLOTS));
    slot_addr = slot_ext[IDX_W-1:0];
    last      = (idx == IDX_W'(NUM_SLOTS - 1));

    hit = en[idx] && (ram_rdata.hour == t_hour) && (ram_rdata.minute == t_minute) &&
          (ram_rdata.second == t_second);

    hit_bits = '0;
    for (int j = 0; j < int'(atm_pkg::MASK_W); j++) begin
      if ((j < int'(NUM_SLOTS)) && (idx == IDX_W'(j))) begin
        hit_bits[j] = hit;
      end
    end

    // Write port: slot load on a set, hour write-back on a periodic hit.
    if (state == atm_pkg::ST_SCAN) begin
      ram_we         = hit && (ram_rdata.mode == atm_pkg::MODE_PERIODIC);
      ram_waddr      = idx;
      ram_wdata      = ram_rdata;
      ram_wdata.hour = atm_pkg::hour_advance(ram_rdata.hour, ram_rdata.period);
    end else begin
      ram_we           = accept && is_set && slot_ok;
      ram_waddr        = slot_addr;
      ram_wdata.mode   = atm_pkg::mode_e'(req.mode);
      ram_wdata.hour   = req.hour;
      ram_wdata.minute = req.minute;
      ram_wdata.second = req.second;
      ram_wdata.period = req.period;
    end

    // Read port runs one entry ahead of the compare.
    if (state == atm_pkg::ST_SCAN) begin
      ram_re    = !last;
      ram_raddr = IDX_W'(idx + 1'b1);
    end else begin
      ram_re    = accept && !is_set;
      ram_raddr = '0;
    end

    res.vld        = (state == atm_pkg::ST_DONE);
    res.fired_mask = mask;

    state_next = state;
    unique case (state)
      atm_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = is_set ? atm_pkg::ST_DONE : atm_pkg::ST_SCAN;
        end
      end
      atm_pkg::ST_SCAN: begin
        if (last) begin
          state_next = atm_pkg::ST_DONE;
        end
      end
      atm_pkg::ST_DONE: begin
        if (res_ready) begin
          state_next = atm_pkg::ST_IDLE;
        end
      end
      default: state_next = atm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      en <= '0;
    end else if (accept && is_set && slot_ok) begin
      en[slot_addr] <= 1'b1;
    end else if ((state == atm_pkg::ST_SCAN) && hit &&
                 (ram_rdata.mode == atm_pkg::MODE_ONCE)) begin
      en[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      mask <= '0;
    end else if (accept) begin
      idx  <= '0;
      mask <= '0;
    end else if (state == atm_pkg::ST_SCAN) begin
      idx  <= last ? idx : IDX_W'(idx + 1'b1);
      mask <= mask | hit_bits;
    end
  end

  // Hold the tick's time for the whole scan.
  always_ff @(posedge clk) begin
    if (accept) begin
      t_hour   <= req.hour;
      t_minute <= req.minute;
      t_second <= req.second;
    end
  end

`ifndef SYNTH
  a_tick_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_set) |=> (state == atm_pkg::ST_SCAN) && (idx == '0) && (mask == '0))
    else $error("tick did not start a scan from slot zero");

  a_set_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && is_set) |=> (state == atm_pkg::ST_DONE) && (mask == '0))
    else $error("set command did not produce an empty mask");

  a_set_enables: assert property (@(posedge clk) disable iff (rst)
    (accept && is_set && slot_ok) |=> en[$past(slot_addr)])
    else $error("set command did not enable its slot");

  a_once_disables: assert property (@(posedge clk) disable iff (rst)
    ((state == atm_pkg::ST_SCAN) && hit && (ram_rdata.mode == atm_pkg::MODE_ONCE))
    |=> !en[$past(idx)])
    else $error("fired once-slot stayed enabled");

  a_no_write_in_done: assert property (@(posedge clk) disable iff (rst)
    (state == atm_pkg::ST_DONE) |-> !ram_we && !ram_re)
    else $error("table accessed while a result waits");
`endif

endmodule

`default_nettype wire

/* rtl/core/alarm_table_time_match.sv */
// ============================================================================
// alarm_table_time_match
// Alarm slot table matched against the time of day, with fired-mask output.
// ============================================================================
// A set item writes hour, minute, second, mode and period into one slot of a
// NUM_SLOTS-entry table and enables it; a set aimed past the table is dropped
// and still returns an all-zero mask. A tick item carries the time of day:
// every enabled slot whose hour, minute and second all equal the tick's
// fires, and its bit (slots 0 to 4 only) is set in the returned fired_mask.
// A fired once-slot disables itself, a fired periodic slot moves its hour on
// by its period modulo 24, and daily or weekly slots stay as they are.
// Every item returns exactly one result. A set goes straight to its result;
// a tick scans the table one slot per cycle, because the slot fields live in
// one memory with a single read port. A new item is taken as soon as the
// previous one has its result parked in the output register, even if the
// sink has not yet taken it.
// ============================================================================
`default_nettype none

module alarm_table_time_match #(
  parameter int unsigned NUM_SLOTS = 5
) (
  input wire logic clk,
  input wire logic rst,
  atm_req_if.sink  req,
  atm_rsp_if.source rsp
);

  atm_pkg::result_t           res;
  logic                       res_ready;
  logic                       out_valid;
  logic [atm_pkg::MASK_W-1:0] out_mask;

  atm_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res       (res),
    .res_ready (res_ready)
  );

  // Take a finished result whenever the output register is empty or drains.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.vld) begin
      out_mask <= res.fired_mask;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.fired_mask = out_mask;

endmodule

`default_nettype wire

/* tb/alarm_table_time_match_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// alarm_table_time_match_checker
// Predicts the fired mask of every accepted command and checks the output.
// ============================================================================
module alarm_table_time_match_checker
  import atm_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 5
) (
  input  logic clk,
  input  logic rst,
  atm_req_if   req,
  atm_rsp_if   rsp,
  output int   errors,
  output int   pending
);

  // Shadow copy of the alarm table.
  logic              armed   [NUM_SLOTS];
  slot_entry_t       alarm   [NUM_SLOTS];
  logic [MASK_W-1:0] mask_q  [$];

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Apply one command to the shadow table and return the mask it produces.
  function automatic logic [MASK_W-1:0] fired_for(
    input cmd_e       cmd,
    input logic [2:0] idx,
    input logic [4:0] h,
    input logic [5:0] m,
    input logic [5:0] s,
    input mode_e      md,
    input logic [7:0] p
  );
    logic [MASK_W-1:0] fired;
    fired = '0;
    if (cmd == CMD_SET) begin
      if (idx < NUM_SLOTS) begin
        armed[idx] = 1'b1;
        alarm[idx] = '{mode: md, hour: h, minute: m, second: s, period: p};
      end
      return fired;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (armed[i] && alarm[i].hour == h && alarm[i].minute == m &&
          alarm[i].second == s) begin
        if (i < MASK_W) fired[i] = 1'b1;
        case (alarm[i].mode)
          MODE_ONCE: armed[i] = 1'b0;
          MODE_PERIODIC:
            alarm[i].hour = 5'((int'(alarm[i].hour) + int'(alarm[i].period)) %
                               HOURS_PER_DAY);
          default: ;
        endcase
      end
    end
    return fired;
  endfunction

  always @(posedge clk) begin : track
    logic [MASK_W-1:0] want;
    if (rst) begin
      errors = 0;
      mask_q.delete();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        armed[i] = 1'b0;
        alarm[i] = '0;
      end
    end else begin
      // Results leave before new commands enter, so the oldest entry matches.
      if (rsp.valid && rsp.ready) begin
        if (mask_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result fired_mask %b", rsp.fired_mask));
        end else begin
          want = mask_q.pop_front();
          if (rsp.fired_mask !== want)
            report_mismatch($sformatf("fired_mask expected %b got %b",
                                      want, rsp.fired_mask));
        end
      end
      if (req.valid && req.ready)
        mask_q.push_back(fired_for(cmd_e'(req.command), req.slot, req.hour, req.minute,
                                   req.second, mode_e'(req.mode), req.period));
    end
    pending <= mask_q.size();
  end

endmodule

/* tb/alarm_table_time_match_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// alarm_table_time_match_tb
// Stimulus and verdict for the alarm table time match block.
// ============================================================================
// Drives set and tick items into the block with random gaps and random
// output stalls. A directed opening covers empty-table ticks, sets aimed
// past the table, once, periodic, daily and weekly firing, out-of-range
// times, wrap of the periodic hour and all slots firing together. The random
// part keeps a small pool of alarm times so that most ticks hit armed slots,
// and now and then steps through all 24 hours at one minute and second so
// periodic slots fire, advance and fire again. A checker module beside the
// block predicts every fired mask and counts mismatches.
// ============================================================================
module alarm_table_time_match_tb;
  import atm_pkg::*;

  localparam int unsigned NUM_SLOTS   = 5;
  localparam int          ITEM_TARGET = 650;
  localparam int          POOL_SIZE   = 6;
  localparam int          QUIET_LIMIT = 1000;
  localparam int          TAIL_CYCLES = NUM_SLOTS + 12;

  logic clk;
  logic rst = 1'b1;

  atm_req_if req_ch ();
  atm_rsp_if rsp_ch ();

  int   errors;
  int   pending;
  int   sent;
  int   quiet_cycles;
  logic req_burst;
  logic rsp_burst;

  // Alarm time pool shared by sets and ticks, reshuffled each phase.
  logic [4:0] pool_h [POOL_SIZE];
  logic [5:0] pool_m [POOL_SIZE];
  logic [5:0] pool_s [POOL_SIZE];

  alarm_table_time_match #(.NUM_SLOTS(NUM_SLOTS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  alarm_table_time_match_checker #(.NUM_SLOTS(NUM_SLOTS)) checker_i (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hand one item to the block: idle a random number of cycles, then hold
  // valid with the payload until the block takes it. Valid stays high into
  // the next item when that one draws no gap.
  task automatic issue(input cmd_e cmd, input logic [2:0] idx, input logic [4:0] h,
                       input logic [5:0] m, input logic [5:0] s, input mode_e md,
                       input logic [7:0] p);
    int gap;
    gap = req_burst ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= cmd;
    req_ch.slot    <= idx;
    req_ch.hour    <= h;
    req_ch.minute  <= m;
    req_ch.second  <= s;
    req_ch.mode    <= md;
    req_ch.period  <= p;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  // A tick carries slot, mode and period too; fill them with noise since the
  // block must ignore them.
  task automatic tick(input logic [4:0] h, input logic [5:0] m, input logic [5:0] s);
    issue(CMD_TICK, 3'($urandom_range(0, 7)), h, m, s, mode_e'($urandom_range(0, 3)),
          8'($urandom_range(0, 255)));
  endtask

  task automatic reshuffle_phase();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_h[i] = 5'($urandom_range(0, 23));
      pool_m[i] = 6'($urandom_range(0, 59));
      pool_s[i] = 6'($urandom_range(0, 59));
    end
    // On each side, roughly a quarter of the phases run without gaps.
    req_burst = ($urandom_range(0, 3) == 0);
    rsp_burst = ($urandom_range(0, 3) == 0);
  endtask

  // Result sink: stall a random number of cycles per item, then take it.
  initial begin : sink
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rsp_burst ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("alarm_table_time_match verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int          pick;
    int          k;
    int          next_phase;
    logic [2:0]  idx;
    logic [4:0]  h;
    logic [5:0]  m;
    logic [5:0]  s;

    sent         = 0;
    req_burst    = 1'b0;
    rsp_burst    = 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.command <= CMD_TICK;
    req_ch.slot    <= '0;
    req_ch.hour    <= '0;
    req_ch.minute  <= '0;
    req_ch.second  <= '0;
    req_ch.mode    <= MODE_ONCE;
    req_ch.period  <= '0;

    // Hold reset, then release it for good.
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed opening ----
    // Empty table: a tick at midnight must fire nothing.
    tick(5'd0, 6'd0, 6'd0);
    // Sets aimed past the table are dropped; a midnight tick still fires nothing.
    issue(CMD_SET, 3'd7, 5'd0, 6'd0, 6'd0, MODE_DAILY, 8'd0);
    issue(CMD_SET, 3'd5, 5'd0, 6'd0, 6'd0, MODE_ONCE, 8'd1);
    tick(5'd0, 6'd0, 6'd0);
    // Once alarm at the last second of the day: fires, then disarms.
    issue(CMD_SET, 3'd0, 5'd23, 6'd59, 6'd59, MODE_ONCE, 8'd0);
    tick(5'd23, 6'd59, 6'd59);
    tick(5'd23, 6'd59, 6'd59);
    // Periodic with the largest period: 20 + 255 wraps to hour 11.
    issue(CMD_SET, 3'd1, 5'd20, 6'd0, 6'd0, MODE_PERIODIC, 8'd255);
    tick(5'd20, 6'd0, 6'd0);
    tick(5'd11, 6'd0, 6'd0);
    // Daily, weekly and zero-period periodic all stay put after firing.
    issue(CMD_SET, 3'd2, 5'd12, 6'd30, 6'd30, MODE_DAILY, 8'd7);
    issue(CMD_SET, 3'd3, 5'd12, 6'd30, 6'd30, MODE_WEEKLY, 8'd200);
    issue(CMD_SET, 3'd4, 5'd12, 6'd30, 6'd30, MODE_PERIODIC, 8'd0);
    tick(5'd12, 6'd30, 6'd30);
    tick(5'd12, 6'd30, 6'd30);
    // Out-of-range time stored as given; the tick carries every field at max.
    issue(CMD_SET, 3'd0, 5'd31, 6'd63, 6'd63, MODE_ONCE, 8'd255);
    issue(CMD_TICK, 3'd7, 5'd31, 6'd63, 6'd63, MODE_WEEKLY, 8'd255);
    // All five slots on one time: a full mask, then the once slot drops out.
    issue(CMD_SET, 3'd1, 5'd12, 6'd30, 6'd30, MODE_PERIODIC, 8'd24);
    issue(CMD_SET, 3'd0, 5'd12, 6'd30, 6'd30, MODE_ONCE, 8'd0);
    tick(5'd12, 6'd30, 6'd30);
    tick(5'd12, 6'd30, 6'd30);
    // Near misses on second and hour.
    tick(5'd12, 6'd30, 6'd31);
    tick(5'd13, 6'd30, 6'd30);

    // ---- Random part ----
    next_phase = sent;
    while (sent < ITEM_TARGET) begin
      if (sent >= next_phase) begin
        reshuffle_phase();
        next_phase = sent + 40;
      end
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, POOL_SIZE - 1);
      if (pick < 3) begin
        // Step a clock through every hour at one pool minute and second.
        for (int hr = 0; hr < 24; hr++) tick(5'(hr), pool_m[k], pool_s[k]);
      end else if (pick < 33) begin
        // Mostly slots in the table, sometimes past it.
        idx = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, NUM_SLOTS - 1));
        if ($urandom_range(0, 9) < 8) begin
          h = pool_h[k];
          m = pool_m[k];
          s = pool_s[k];
        end else begin
          h = 5'($urandom_range(0, 31));
          m = 6'($urandom_range(0, 63));
          s = 6'($urandom_range(0, 63));
        end
        issue(CMD_SET, idx, h, m, s, mode_e'($urandom_range(0, 3)),
              8'($urandom_range(0, 255)));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          tick(pool_h[k], pool_m[k], pool_s[k]);
        end else if (pick < 8) begin
          // Any hour at a pool minute and second catches advanced periodics.
          tick(5'($urandom_range(0, 23)), pool_m[k], pool_s[k]);
        end else begin
          tick(5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
               6'($urandom_range(0, 63)));
        end
      end
    end
    req_ch.valid <= 1'b0;

    // Drain: wait for every outstanding mask, then idle for a tail period so that
    // a stray extra result would still be seen.
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("alarm_table_time_match verification clean");
    end else begin
      $display("alarm_table_time_match verification failed");
    end
    $finish;
  end

endmodule

/* alarm_table_time_match.f */
rtl/core/atm_pkg.sv
rtl/core/atm_if.sv
rtl/core/atm_ram.sv
rtl/core/atm_ctrl.sv
rtl/core/alarm_table_time_match.sv
tb/alarm_table_time_match_checker.sv
tb/alarm_table_time_match_tb.sv
